// ===== src/delta_list_sleep_timer_core_defines.svh =====
// assertion macros shared by the sleep timer rtl
// needs clk and rst_n in the scope of each use
`ifndef DELTA_LIST_SLEEP_TIMER_CORE_DEFINES_SVH
`define DELTA_LIST_SLEEP_TIMER_CORE_DEFINES_SVH

// same-cycle implication
`define DLST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dlst_pkg.sv =====
// types and codes for the delta list sleep timer
// no dependencies
package dlst_pkg;

  localparam int CNT_W = 6;

  localparam logic [1:0] REQ_SLEEP  = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [2:0] EV_SLEEP_OK  = 3'd0;
  localparam logic [2:0] EV_POOL_FULL = 3'd1;
  localparam logic [2:0] EV_REMOVED   = 3'd2;
  localparam logic [2:0] EV_UNBLOCK   = 3'd3;
  localparam logic [2:0] EV_ALARM     = 3'd4;
  localparam logic [2:0] EV_TICK_DONE = 3'd5;

  localparam logic REG_TICK_MS   = 1'b0;
  localparam logic REG_TIMESLICE = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] thread_id;
    logic [31:0] sleep_ms;
    logic        blocking;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] event_thread;
    logic        resched;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] thread;
    logic [31:0] delta;
    logic        blocking;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DROP,
    OP_HEAD_SUB
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    entry_t           ins;
    logic [31:0]      adj;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLEEP,
    ST_REMOVE,
    ST_TICK,
    ST_REPLY
  } state_t;

endpackage

// ===== src/dlst_cell.sv =====
// one list slot: holds an entry and shifts to or from its neighbors
// depends on dlst_pkg
module dlst_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  dlst_pkg::cell_ctrl_t ctrl,
  input  dlst_pkg::entry_t    left_q,
  input  dlst_pkg::entry_t    right_q,
  output dlst_pkg::entry_t    q
);

  localparam logic [dlst_pkg::CNT_W-1:0] MY_IDX = dlst_pkg::CNT_W'(IDX);

  dlst_pkg::entry_t ent_r;
  dlst_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      dlst_pkg::OP_INSERT: begin
        if (MY_IDX == ctrl.pos) begin
          ent_nxt = ctrl.ins;
        end else if (MY_IDX > ctrl.pos) begin
          ent_nxt = left_q;
          // old successor gives up the new entry's delta
          if (MY_IDX == ctrl.pos + 1'b1) ent_nxt.delta = left_q.delta - ctrl.adj;
        end
      end
      dlst_pkg::OP_DROP: begin
        if (MY_IDX >= ctrl.pos) ent_nxt = right_q;
        // successor takes over whatever delta the caller hands on
        if (MY_IDX == ctrl.pos) ent_nxt.delta = right_q.delta + ctrl.adj;
      end
      dlst_pkg::OP_HEAD_SUB: begin
        if (MY_IDX == '0) ent_nxt.delta = ent_r.delta - ctrl.adj;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;

endmodule

// ===== src/delta_list_sleep_timer_core.sv =====
// Sleep timer pool as a row of ENTRIES slot cells sorted by deadline, each holding its delta
// to the previous slot. A sleep walks the list one slot per cycle to find its place, then
// shifts the tail across the cells at once. A remove walks until the thread matches, then
// drops that slot. A tick reports and drops expired head entries one by one, stalling while
// the output register is full, then subtracts what is left of the tick from the new head.
// Results leave through an output register; a pool-full sleep skips the walk and replies.
// depends on dlst_pkg, dlst_cell and delta_list_sleep_timer_core_defines.svh
`include "delta_list_sleep_timer_core_defines.svh"
module delta_list_sleep_timer_core #(
  parameter int ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlst_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CW = dlst_pkg::CNT_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  dlst_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [9:0]          inc_r, inc_nxt;
  logic                woke_r, woke_nxt;
  logic [31:0]         elapsed_r, elapsed_nxt;
  logic [31:0]         last_rs_r, last_rs_nxt;
  logic [9:0]          tick_ms_r;
  logic [15:0]         tslice_r;
  dlst_pkg::in_item_t  req_r, req_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic                rs_r, rs_nxt;
  logic                out_valid_r, out_valid_nxt;
  dlst_pkg::out_item_t out_data_r, out_data_nxt;

  dlst_pkg::cell_ctrl_t ctrl;
  dlst_pkg::entry_t     cell_q [ENTRIES];
  dlst_pkg::entry_t     head, cur;
  logic [32:0]          sum;
  logic                 out_free;
  logic                 expire;

  // slot row
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dlst_pkg::entry_t lq, rq;
    if (g == 0) begin : g_first
      assign lq = '0;
    end else begin : g_mid
      assign lq = cell_q[g-1];
    end
    if (g == ENTRIES - 1) begin : g_lastc
      assign rq = cell_q[g];
    end else begin : g_inner
      assign rq = cell_q[g+1];
    end
    dlst_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (lq),
      .right_q (rq),
      .q       (cell_q[g])
    );
  end

  assign head     = cell_q[0];
  assign cur      = cell_q[idx_r[IW-1:0]];
  assign sum      = {1'b0, acc_r} + {1'b0, cur.delta};
  assign out_free = !out_valid_r || out_ready;
  assign expire   = (cnt_r != '0) && (head.delta <= {22'd0, inc_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlst_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            dlst_pkg::REQ_SLEEP:
              state_nxt = (cnt_r >= FULL_CNT) ? dlst_pkg::ST_REPLY : dlst_pkg::ST_SLEEP;
            dlst_pkg::REQ_REMOVE: state_nxt = dlst_pkg::ST_REMOVE;
            dlst_pkg::REQ_TICK:   state_nxt = dlst_pkg::ST_TICK;
            default:              state_nxt = dlst_pkg::ST_IDLE;
          endcase
        end
      end
      dlst_pkg::ST_SLEEP: begin
        if (!(idx_r < cnt_r && sum <= {1'b0, req_r.sleep_ms})) state_nxt = dlst_pkg::ST_REPLY;
      end
      dlst_pkg::ST_REMOVE: begin
        if (idx_r >= cnt_r || cur.thread == req_r.thread_id) state_nxt = dlst_pkg::ST_REPLY;
      end
      dlst_pkg::ST_TICK: begin
        if (!expire) state_nxt = dlst_pkg::ST_REPLY;
      end
      dlst_pkg::ST_REPLY: begin
        if (out_free) state_nxt = dlst_pkg::ST_IDLE;
      end
      default: state_nxt = dlst_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready      = (state_r == dlst_pkg::ST_IDLE);
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    inc_nxt       = inc_r;
    woke_nxt      = woke_r;
    elapsed_nxt   = elapsed_r;
    last_rs_nxt   = last_rs_r;
    req_nxt       = req_r;
    kind_nxt      = kind_r;
    rs_nxt        = rs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctrl.op       = dlst_pkg::OP_HOLD;
    ctrl.pos      = idx_r;
    ctrl.ins      = '{thread: req_r.thread_id, delta: req_r.sleep_ms - acc_r,
                      blocking: req_r.blocking};
    ctrl.adj      = req_r.sleep_ms - acc_r;
    case (state_r)
      dlst_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          idx_nxt  = '0;
          acc_nxt  = '0;
          rs_nxt   = 1'b0;
          inc_nxt  = tick_ms_r;
          woke_nxt = 1'b0;
          kind_nxt = dlst_pkg::EV_POOL_FULL;
          if (in_data.req_type == dlst_pkg::REQ_TICK) elapsed_nxt = elapsed_r + {22'd0, tick_ms_r};
        end
      end
      dlst_pkg::ST_SLEEP: begin
        if (idx_r < cnt_r && sum <= {1'b0, req_r.sleep_ms}) begin
          acc_nxt = sum[31:0];
          idx_nxt = idx_r + 1'b1;
        end else begin
          ctrl.op  = dlst_pkg::OP_INSERT;
          cnt_nxt  = cnt_r + 1'b1;
          kind_nxt = dlst_pkg::EV_SLEEP_OK;
        end
      end
      dlst_pkg::ST_REMOVE: begin
        kind_nxt = dlst_pkg::EV_REMOVED;
        if (idx_r < cnt_r) begin
          if (cur.thread == req_r.thread_id) begin
            // removed entry's delta moves on to its successor
            ctrl.op  = dlst_pkg::OP_DROP;
            ctrl.adj = cur.delta;
            cnt_nxt  = cnt_r - 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      dlst_pkg::ST_TICK: begin
        kind_nxt = dlst_pkg::EV_TICK_DONE;
        ctrl.pos = '0;
        ctrl.adj = {22'd0, inc_r};
        if (expire) begin
          // head expired: report it and pull the list forward
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{event_kind: head.blocking ? dlst_pkg::EV_UNBLOCK
                                                        : dlst_pkg::EV_ALARM,
                              event_thread: head.thread, resched: 1'b0, last: 1'b0};
            woke_nxt = woke_r | head.blocking;
            inc_nxt  = inc_r - head.delta[9:0];
            ctrl.op  = dlst_pkg::OP_DROP;
            ctrl.adj = '0;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end else begin
          if (cnt_r != '0) ctrl.op = dlst_pkg::OP_HEAD_SUB;
          if (woke_r || (elapsed_r - last_rs_r) >= {16'd0, tslice_r}) begin
            rs_nxt      = 1'b1;
            last_rs_nxt = elapsed_r;
          end
        end
      end
      dlst_pkg::ST_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{event_kind: kind_r,
                            event_thread: (kind_r == dlst_pkg::EV_TICK_DONE) ? 16'd0
                                                                             : req_r.thread_id,
                            resched: rs_r, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlst_pkg::ST_IDLE;
      cnt_r       <= '0;
      elapsed_r   <= '0;
      last_rs_r   <= '0;
      out_valid_r <= 1'b0;
      tick_ms_r   <= 10'd10;
      tslice_r    <= 16'd50;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      last_rs_r   <= last_rs_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2] == dlst_pkg::REG_TICK_MS) tick_ms_r <= pwdata[9:0];
        else tslice_r <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    inc_r      <= inc_nxt;
    woke_r     <= woke_nxt;
    req_r      <= req_nxt;
    kind_r     <= kind_nxt;
    rs_r       <= rs_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == dlst_pkg::REG_TICK_MS) ? {22'd0, tick_ms_r}
                                                         : {16'd0, tslice_r};

  `DLST_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "entry count above pool size")
  `DLST_ASSERT_NXT(a_one_item,
    in_valid && in_ready && (state_nxt != dlst_pkg::ST_IDLE), !in_ready,
    "second item taken while busy")
  `DLST_ASSERT_IMP(a_insert_room, ctrl.op == dlst_pkg::OP_INSERT, cnt_r < FULL_CNT,
    "insert into full pool")

endmodule

// ===== tb/sv/tb_delta_list_sleep_timer_core.sv =====
// testbench for delta_list_sleep_timer_core: sleep, remove and tick transactions against
// a behavioral delta-list timer model, with random idling on both channels
// depends on dlst_pkg and the rtl under src
`timescale 1ns / 1ps
module tb_delta_list_sleep_timer_core;

  localparam int POOL = 32;
  localparam logic [2:0] ADDR_TICK = 3'd0;
  localparam logic [2:0] ADDR_SLICE = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dlst_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dlst_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  delta_list_sleep_timer_core #(.ENTRIES(POOL)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer model state
  logic [15:0] slot_thread[POOL];
  logic [31:0] slot_delta[POOL];
  logic slot_blocking[POOL];
  int slot_count;
  logic [31:0] now_ms;
  logic [31:0] resched_mark_ms;
  logic [9:0] tick_len_ms;
  logic [15:0] slice_len_ms;

  dlst_pkg::out_item_t pending_events[$];
  int errors = 0;

  task automatic push_event(logic [2:0] kind, logic [15:0] thr, logic rs, logic lst);
    dlst_pkg::out_item_t ev;
    ev.event_kind = kind;
    ev.event_thread = thr;
    ev.resched = rs;
    ev.last = lst;
    pending_events.push_back(ev);
  endtask

  task automatic shift_out_slot(int pos);
    for (int i = pos; i + 1 < slot_count; i++) begin
      slot_thread[i] = slot_thread[i + 1];
      slot_delta[i] = slot_delta[i + 1];
      slot_blocking[i] = slot_blocking[i + 1];
    end
    if (slot_count > 0) slot_count--;
  endtask

  task automatic predict_timer(dlst_pkg::in_item_t it);
    logic [32:0] acc;
    int pos;
    logic [31:0] d;
    logic [31:0] inc;
    logic woke;
    logic rs;
    acc = '0;
    pos = 0;
    woke = 1'b0;
    rs = 1'b0;
    case (it.req_type)
      dlst_pkg::REQ_SLEEP: begin
        if (slot_count >= POOL) begin
          push_event(dlst_pkg::EV_POOL_FULL, it.thread_id, 1'b0, 1'b1);
        end else begin
          while (pos < slot_count && acc + slot_delta[pos] <= {1'b0, it.sleep_ms}) begin
            acc += slot_delta[pos];
            pos++;
          end
          d = it.sleep_ms - acc[31:0];
          for (int i = slot_count; i > pos; i--) begin
            slot_thread[i] = slot_thread[i - 1];
            slot_delta[i] = slot_delta[i - 1];
            slot_blocking[i] = slot_blocking[i - 1];
          end
          slot_thread[pos] = it.thread_id;
          slot_delta[pos] = d;
          slot_blocking[pos] = it.blocking;
          slot_count++;
          if (pos + 1 < slot_count) slot_delta[pos + 1] -= d;
          push_event(dlst_pkg::EV_SLEEP_OK, it.thread_id, 1'b0, 1'b1);
        end
      end
      dlst_pkg::REQ_REMOVE: begin
        for (int i = 0; i < slot_count; i++) begin
          if (slot_thread[i] == it.thread_id) begin
            if (i + 1 < slot_count) slot_delta[i + 1] += slot_delta[i];
            shift_out_slot(i);
            break;
          end
        end
        push_event(dlst_pkg::EV_REMOVED, it.thread_id, 1'b0, 1'b1);
      end
      dlst_pkg::REQ_TICK: begin
        inc = {22'd0, tick_len_ms};
        now_ms += inc;
        while (slot_count > 0) begin
          if (slot_delta[0] > inc) begin
            slot_delta[0] -= inc;
            break;
          end
          inc -= slot_delta[0];
          if (slot_blocking[0]) woke = 1'b1;
          push_event(slot_blocking[0] ? dlst_pkg::EV_UNBLOCK : dlst_pkg::EV_ALARM,
                     slot_thread[0], 1'b0, 1'b0);
          shift_out_slot(0);
        end
        if (woke || (now_ms - resched_mark_ms) >= {16'd0, slice_len_ms}) begin
          resched_mark_ms = now_ms;
          rs = 1'b1;
        end
        push_event(dlst_pkg::EV_TICK_DONE, 16'd0, rs, 1'b1);
      end
      default: ;
    endcase
  endtask

  // result checker with random backpressure
  initial begin
    int hold;
    dlst_pkg::out_item_t exp_ev;
    @(posedge clk iff rst_n);
    forever begin
      hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_data !== exp_ev) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_ev, out_data);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [1:0] req, logic [15:0] thr, logic [31:0] ms, logic blk);
    dlst_pkg::in_item_t it;
    int hold;
    it.req_type = req;
    it.thread_id = thr;
    it.sleep_ms = ms;
    it.blocking = blk;
    hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
    if (hold != 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    predict_timer(it);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_events.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TICK) tick_len_ms = val[9:0];
    else if (addr == ADDR_SLICE) slice_len_ms = val[15:0];
  endtask

  task automatic test_directed();
    send_request(dlst_pkg::REQ_REMOVE, 16'hFFFF, 32'd0, 1'b0);     // remove from empty pool
    send_request(dlst_pkg::REQ_SLEEP, 16'd1, 32'd0, 1'b1);
    send_request(dlst_pkg::REQ_SLEEP, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(dlst_pkg::REQ_SLEEP, 16'd2, 32'd15, 1'b0);
    send_request(dlst_pkg::REQ_SLEEP, 16'd3, 32'd15, 1'b1);         // equal deadline goes after
    send_request(dlst_pkg::REQ_SLEEP, 16'd4, 32'd5, 1'b0);
    send_request(2'd3, 16'hAAAA, 32'h5555_5555, 1'b1);              // unknown request, no result
    send_request(dlst_pkg::REQ_TICK, 16'h1234, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_REMOVE, 16'd2, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_REMOVE, 16'd77, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_TICK, 16'd0, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_TICK, 16'd0, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_REMOVE, 16'hFFFF, 32'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < POOL + 2; i++)
      send_request(dlst_pkg::REQ_SLEEP, 16'(i * 2053), $urandom_range(0, 150), 1'($urandom));
    for (int i = 0; i < 15; i++) send_request(dlst_pkg::REQ_TICK, 16'd0, 32'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_zero_tick();
    write_reg(ADDR_TICK, 32'd0);
    write_reg(ADDR_SLICE, 32'd1);
    send_request(dlst_pkg::REQ_SLEEP, 16'd9, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_SLEEP, 16'd10, 32'd0, 1'b1);
    send_request(dlst_pkg::REQ_SLEEP, 16'd11, 32'd3, 1'b1);
    send_request(dlst_pkg::REQ_TICK, 16'd0, 32'd0, 1'b0);
    send_request(dlst_pkg::REQ_REMOVE, 16'd11, 32'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int n, logic [31:0] max_ms);
    logic [1:0] req;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: req = dlst_pkg::REQ_SLEEP;
        4, 5: req = dlst_pkg::REQ_REMOVE;
        9: req = 2'd3;
        default: req = dlst_pkg::REQ_TICK;
      endcase
      send_request(req, $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                   $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, max_ms),
                   1'($urandom));
      if (i == n / 2) wait_drained();   // let the pipeline empty mid-run
    end
    wait_drained();
  endtask

  initial begin
    slot_count = 0;
    now_ms = '0;
    resched_mark_ms = '0;
    tick_len_ms = 10'd10;
    slice_len_ms = 16'd50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_zero_tick();
    write_reg(ADDR_TICK, 32'd1000);
    write_reg(ADDR_SLICE, 32'd65535);
    test_random(15, 5000);
    write_reg(ADDR_TICK, 32'd1);
    write_reg(ADDR_SLICE, 32'd3);
    test_random(14, 20);
    write_reg(ADDR_TICK, 32'hFFFF_FC07);  // upper bits must be masked off
    write_reg(ADDR_SLICE, 32'hFFFF_0000);
    test_random(14, 60);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== delta_list_sleep_timer_core.f =====
+incdir+src
src/dlst_pkg.sv
src/dlst_cell.sv
src/delta_list_sleep_timer_core.sv
tb/sv/tb_delta_list_sleep_timer_core.sv
